// ===== rtl/core/countdown_timer_with_display_assert.svh =====
// Assertion macros used by the checker file of the countdown timer.
`ifndef COUNTDOWN_TIMER_WITH_DISPLAY_ASSERT_SVH
`define COUNTDOWN_TIMER_WITH_DISPLAY_ASSERT_SVH

// Checked only while the block is out of reset.
`define CTD_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// Checked at every edge, reset included.
`define CTD_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

// ===== rtl/core/ctd_pkg.sv =====
// Shared types, codes, constants and display arithmetic of the countdown timer.
`default_nettype none

package ctd_pkg;

    localparam int unsigned COUNT_W = 13;
    localparam logic [COUNT_W-1:0] HARD_MAX_SECONDS = 13'd5999;

    // Configuration register indexes.
    localparam logic [2:0] REG_TICKS_PER_SECOND = 3'd0;
    localparam logic [2:0] REG_SCAN_PERIOD      = 3'd1;
    localparam logic [2:0] REG_SMALL_STEP       = 3'd2;
    localparam logic [2:0] REG_LARGE_STEP       = 3'd3;
    localparam logic [2:0] REG_STEP_THRESHOLD   = 3'd4;
    localparam logic [2:0] REG_MAX_SECONDS      = 3'd5;

    // Configuration reset values.
    localparam logic [15:0] RST_TICKS_PER_SECOND = 16'd20000;
    localparam logic [15:0] RST_SCAN_PERIOD      = 16'd400;
    localparam logic [7:0]  RST_SMALL_STEP       = 8'd15;
    localparam logic [7:0]  RST_LARGE_STEP       = 8'd59;
    localparam logic [12:0] RST_STEP_THRESHOLD   = 13'd1180;
    localparam logic [12:0] RST_MAX_SECONDS      = 13'd5999;

    // Segment patterns, active low, a in bit 0 and dp in bit 7.
    localparam logic [7:0] SEG_BLANK    = 8'hff;
    localparam logic [7:0] SEG_DP_MASK  = 8'h7f;

    typedef enum logic [1:0] {
        REQ_TICK    = 2'd0,
        REQ_BUTTON  = 2'd1,
        REQ_ENCODER = 2'd2,
        REQ_NONE    = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        RESUME_FRESH  = 2'd0,
        RESUME_PAUSED = 2'd1,
        RESUME_ACKED  = 2'd2
    } resume_t;

    // Timer state handed to the display decoder.
    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [1:0]         digit;
        logic               alarm;
        logic               lamp;
    } ctd_disp_t;

    // One result word.
    typedef struct packed {
        logic [7:0]         segments;
        logic [3:0]         digit_enable;
        logic               buzzer_on;
        logic               run_lamp;
        logic [COUNT_W-1:0] seconds_left;
    } ctd_result_t;

    function automatic logic [7:0] seg_font(input logic [3:0] digit);
        logic [7:0] pattern;
        case (digit)
            4'd0:    pattern = 8'hc0;
            4'd1:    pattern = 8'hf9;
            4'd2:    pattern = 8'ha4;
            4'd3:    pattern = 8'hb0;
            4'd4:    pattern = 8'h99;
            4'd5:    pattern = 8'h92;
            4'd6:    pattern = 8'h82;
            4'd7:    pattern = 8'hf8;
            4'd8:    pattern = 8'h80;
            4'd9:    pattern = 8'h90;
            default: pattern = SEG_BLANK;
        endcase
        return pattern;
    endfunction

    // Quotient by 60 for counts up to 5999: multiply by 2^20/60 rounded up.
    function automatic logic [6:0] div60(input logic [COUNT_W-1:0] value);
        logic [27:0] product;
        product = 28'(value) * 28'd17477;
        return product[26:20];
    endfunction

    // Quotient by 10 for values up to 99: multiply by 2^11/10 rounded up.
    function automatic logic [3:0] div10(input logic [6:0] value);
        logic [14:0] product;
        product = 15'(value) * 15'd205;
        return product[14:11];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/countdown_timer_with_display.sv =====
// Top level of the countdown timer with multiplexed 7-segment display output.
//
//  channel   direction  handshake          payload
//  s_        in         s_valid/s_ready    s_req_type, s_encoder_dir
//  m_        out        m_valid/m_ready    m_segments, m_digit_enable, m_buzzer_on,
//                                          m_run_lamp, m_seconds_left
//  cfg_      in         cfg_wr_en          cfg_addr, cfg_wdata
//
// One word is accepted per cycle while s_ready is high; each word gives one result word,
// through input register, timer state update, display decode into the output register.
// The timer state is updated in the single cycle a word leaves the input register.
// Reset is synchronous on aresetn low and restores the default configuration.
// Each stage holds its word while the stage after it is full, so a stalled result
// still leaves room for two more words behind it.
`default_nettype none

module countdown_timer_with_display (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_req_type,
    input  wire logic        s_encoder_dir,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_segments,
    output logic [3:0]       m_digit_enable,
    output logic             m_buzzer_on,
    output logic             m_run_lamp,
    output logic [12:0]      m_seconds_left,
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_addr,
    input  wire logic [15:0] cfg_wdata
);

    // Configuration registers.
    logic [15:0] ticks_per_second_reg;
    logic [15:0] scan_period_reg;
    logic [7:0]  small_step_reg;
    logic [7:0]  large_step_reg;
    logic [12:0] step_threshold_reg;
    logic [12:0] max_seconds_reg;

    // Pipeline registers.
    logic              in_valid_reg;
    ctd_pkg::req_t     req_reg;
    logic              dir_reg;
    logic              mid_valid_reg;
    ctd_pkg::ctd_disp_t mid_reg;
    logic              out_valid_reg;
    ctd_pkg::ctd_result_t out_reg;

    // Timer state.
    logic             running_reg,   running_next;
    logic [12:0]      count_reg,     count_next;
    logic             alarm_reg,     alarm_next;
    ctd_pkg::resume_t resume_reg,    resume_next;
    logic [12:0]      preset_reg,    preset_next;
    logic [15:0]      prescaler_reg, prescaler_next;
    logic [15:0]      scan_cnt_reg,  scan_cnt_next;
    logic [1:0]       digit_reg,     digit_next;
    logic             lamp_reg,      lamp_next;

    logic        out_ready;
    logic        mid_ready;
    logic        in_ready;
    logic        item_advance;
    logic [12:0] top_limit;
    logic [12:0] count_pre;
    logic [12:0] count_work;
    logic [7:0]  step;
    logic [13:0] enc_sum;
    logic [12:0] enc_value;
    ctd_pkg::ctd_result_t decoded;

    assign out_ready    = !out_valid_reg || m_ready;
    assign mid_ready    = !mid_valid_reg || out_ready;
    assign in_ready     = !in_valid_reg || mid_ready;
    assign item_advance = in_valid_reg && mid_ready;
    assign s_ready      = in_ready;

    always_comb begin
        top_limit = (max_seconds_reg < ctd_pkg::HARD_MAX_SECONDS) ? max_seconds_reg
                                                                 : ctd_pkg::HARD_MAX_SECONDS;
        // A lowered limit takes effect before the word is applied.
        count_pre = (count_reg > top_limit) ? top_limit : count_reg;

        step    = (count_pre < step_threshold_reg) ? small_step_reg : large_step_reg;
        enc_sum = {1'b0, count_pre} + 14'(step);
        if (dir_reg) begin
            enc_value = (13'(step) > count_pre) ? 13'd0 : count_pre - 13'(step);
        end else begin
            enc_value = (enc_sum > {1'b0, top_limit}) ? top_limit : enc_sum[12:0];
        end

        running_next   = running_reg;
        count_work     = count_pre;
        alarm_next     = alarm_reg;
        resume_next    = resume_reg;
        preset_next    = preset_reg;
        prescaler_next = prescaler_reg;
        scan_cnt_next  = scan_cnt_reg;
        digit_next     = digit_reg;
        lamp_next      = lamp_reg;

        case (req_reg)
            ctd_pkg::REQ_TICK: begin
                if (prescaler_reg >= ticks_per_second_reg) begin
                    prescaler_next = '0;
                    if (running_reg) begin
                        if (count_pre == 13'd0) begin
                            resume_next = ctd_pkg::RESUME_FRESH;
                            alarm_next  = 1'b1;
                        end else begin
                            alarm_next = 1'b0;
                            count_work = count_pre - 13'd1;
                        end
                    end
                end else begin
                    prescaler_next = prescaler_reg + 16'd1;
                end
                if (scan_cnt_reg >= scan_period_reg) begin
                    scan_cnt_next = '0;
                    digit_next    = digit_reg + 2'd1;
                end else begin
                    scan_cnt_next = scan_cnt_reg + 16'd1;
                end
            end
            ctd_pkg::REQ_BUTTON: begin
                if (!running_reg) begin
                    if (count_pre != 13'd0) begin
                        lamp_next = 1'b1;
                    end
                    running_next = 1'b1;
                    // Resuming from a pause keeps the saved preset.
                    if (resume_reg != ctd_pkg::RESUME_PAUSED) begin
                        resume_next = ctd_pkg::RESUME_FRESH;
                        if (count_pre != 13'd0) begin
                            preset_next = count_pre;
                        end
                    end
                end else begin
                    if (alarm_reg) begin
                        alarm_next  = 1'b0;
                        count_work  = preset_reg;
                        resume_next = ctd_pkg::RESUME_ACKED;
                    end else begin
                        resume_next = ctd_pkg::RESUME_PAUSED;
                    end
                    running_next = 1'b0;
                    lamp_next    = 1'b0;
                end
            end
            ctd_pkg::REQ_ENCODER: begin
                if (!running_reg) begin
                    count_work = enc_value;
                end
            end
            default: begin
            end
        endcase

        count_next = (count_work > top_limit) ? top_limit : count_work;
        if (alarm_next) begin
            lamp_next = 1'b0;
        end
    end

    ctd_display u_display (
        .disp (mid_reg),
        .res  (decoded)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ticks_per_second_reg <= ctd_pkg::RST_TICKS_PER_SECOND;
            scan_period_reg      <= ctd_pkg::RST_SCAN_PERIOD;
            small_step_reg       <= ctd_pkg::RST_SMALL_STEP;
            large_step_reg       <= ctd_pkg::RST_LARGE_STEP;
            step_threshold_reg   <= ctd_pkg::RST_STEP_THRESHOLD;
            max_seconds_reg      <= ctd_pkg::RST_MAX_SECONDS;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                ctd_pkg::REG_TICKS_PER_SECOND: ticks_per_second_reg <= cfg_wdata;
                ctd_pkg::REG_SCAN_PERIOD:      scan_period_reg      <= cfg_wdata;
                ctd_pkg::REG_SMALL_STEP:       small_step_reg       <= cfg_wdata[7:0];
                ctd_pkg::REG_LARGE_STEP:       large_step_reg       <= cfg_wdata[7:0];
                ctd_pkg::REG_STEP_THRESHOLD:   step_threshold_reg   <= cfg_wdata[12:0];
                ctd_pkg::REG_MAX_SECONDS:      max_seconds_reg      <= cfg_wdata[12:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_reg   <= 1'b0;
            count_reg     <= '0;
            alarm_reg     <= 1'b0;
            resume_reg    <= ctd_pkg::RESUME_FRESH;
            preset_reg    <= '0;
            prescaler_reg <= '0;
            scan_cnt_reg  <= '0;
            digit_reg     <= '0;
            lamp_reg      <= 1'b0;
        end else if (item_advance) begin
            running_reg   <= running_next;
            count_reg     <= count_next;
            alarm_reg     <= alarm_next;
            resume_reg    <= resume_next;
            preset_reg    <= preset_next;
            prescaler_reg <= prescaler_next;
            scan_cnt_reg  <= scan_cnt_next;
            digit_reg     <= digit_next;
            lamp_reg      <= lamp_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            mid_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (in_ready) begin
                in_valid_reg <= s_valid;
            end
            if (mid_ready) begin
                mid_valid_reg <= in_valid_reg;
            end
            if (out_ready) begin
                out_valid_reg <= mid_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && in_ready) begin
            req_reg <= ctd_pkg::req_t'(s_req_type);
            dir_reg <= s_encoder_dir;
        end
        if (item_advance) begin
            mid_reg.count <= count_next;
            mid_reg.digit <= digit_next;
            mid_reg.alarm <= alarm_next;
            mid_reg.lamp  <= lamp_next;
        end
        if (mid_valid_reg && out_ready) begin
            out_reg <= decoded;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_segments     = out_reg.segments;
    assign m_digit_enable = out_reg.digit_enable;
    assign m_buzzer_on    = out_reg.buzzer_on;
    assign m_run_lamp     = out_reg.run_lamp;
    assign m_seconds_left = out_reg.seconds_left;

endmodule

`default_nettype wire

// ===== rtl/core/ctd_display.sv =====
// Converts the seconds count and scan position into one multiplexed display word.
`default_nettype none

module ctd_display (
    input  wire ctd_pkg::ctd_disp_t disp,
    output ctd_pkg::ctd_result_t    res
);

    logic [6:0] mins;
    logic [5:0] secs;
    logic [3:0] mins_tens;
    logic [3:0] mins_units;
    logic [3:0] secs_tens;
    logic [3:0] secs_units;
    logic [3:0] digit_val;
    logic [7:0] pattern;

    always_comb begin
        mins       = ctd_pkg::div60(disp.count);
        secs       = 6'(disp.count - 13'(mins) * 13'd60);
        mins_tens  = ctd_pkg::div10(mins);
        mins_units = 4'(mins - 7'(mins_tens) * 7'd10);
        secs_tens  = ctd_pkg::div10(7'(secs));
        secs_units = 4'(secs - 6'(secs_tens) * 6'd10);

        case (disp.digit)
            2'd0:    digit_val = mins_tens;
            2'd1:    digit_val = mins_units;
            2'd2:    digit_val = secs_tens;
            default: digit_val = secs_units;
        endcase

        pattern = ctd_pkg::seg_font(digit_val);
        // The minutes units digit carries the colon point.
        if (disp.digit == 2'd1) begin
            pattern = pattern & ctd_pkg::SEG_DP_MASK;
        end

        res.segments     = pattern;
        res.digit_enable = 4'b0001 << disp.digit;
        res.buzzer_on    = disp.alarm;
        res.run_lamp     = disp.lamp;
        res.seconds_left = disp.count;
    end

endmodule

`default_nettype wire

// ===== rtl/core/ctd_checker.sv =====
// Port-level checker for the countdown timer, bound to the top level.
`default_nettype none

`include "countdown_timer_with_display_assert.svh"

module ctd_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_valid,
    input wire logic [7:0]  m_segments,
    input wire logic [3:0]  m_digit_enable,
    input wire logic        m_buzzer_on,
    input wire logic        m_run_lamp,
    input wire logic [12:0] m_seconds_left
);

    // Exactly one digit is driven in every result word.
    `CTD_ASSERT(a_digit_onehot, aclk, aresetn, m_valid |-> $onehot(m_digit_enable), "digit enable not one-hot")

    // The shown count never exceeds the hard display limit.
    `CTD_ASSERT(a_count_range, aclk, aresetn, m_valid |-> (m_seconds_left <= 13'd5999), "seconds count above limit")

    // The run lamp is dark whenever the alarm sounds.
    `CTD_ASSERT(a_alarm_lamp, aclk, aresetn, (m_valid && m_buzzer_on) |-> !m_run_lamp, "lamp lit during alarm")

    // Only the minutes units digit lights its point.
    `CTD_ASSERT(a_point, aclk, aresetn, m_valid |-> (m_segments[7] == !m_digit_enable[1]), "decimal point on wrong digit")

    // No result word survives a reset.
    `CTD_ASSERT_ALWAYS(a_reset_flush, aclk, !aresetn |=> !m_valid, "result valid after reset")

endmodule

bind countdown_timer_with_display ctd_checker u_ctd_checker (.*);

`default_nettype wire
